>>> rtl/cfd_pkg.sv
package cfd_pkg;

	localparam int IN_WIDTH_DEF = 32;
	localparam int PAT_W        = 32;
	localparam int EXP_MAX      = 11;
	localparam int DBL_BIAS     = 1023;
	localparam int DBL_SUB_OFS  = 1074;
	localparam int DBL_FRAC_W   = 52;

	typedef enum logic [1:0] {
		CFG_TOTAL_WIDTH = 2'd0,
		CFG_EXP_BITS    = 2'd1,
		CFG_MANT_BITS   = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [4:0] msb;
		logic       zero;
	} lead_t;

endpackage

>>> rtl/cfd_lead_one.sv
module cfd_lead_one
	import cfd_pkg::*;
(
	input  logic [PAT_W-1:0] sig,
	output lead_t            lead
);

	logic [31:0] v32;
	logic [15:0] v16;
	logic [7:0]  v8;
	logic [3:0]  v4;
	logic [1:0]  v2;

	// binary search for the highest set bit
	always_comb begin
		lead.zero = (sig == '0);
		lead.msb  = '0;
		v32 = sig;
		if (v32[31:16] != '0) begin
			lead.msb[4] = 1'b1;
			v16 = v32[31:16];
		end else begin
			v16 = v32[15:0];
		end
		if (v16[15:8] != '0) begin
			lead.msb[3] = 1'b1;
			v8 = v16[15:8];
		end else begin
			v8 = v16[7:0];
		end
		if (v8[7:4] != '0) begin
			lead.msb[2] = 1'b1;
			v4 = v8[7:4];
		end else begin
			v4 = v8[3:0];
		end
		if (v4[3:2] != '0) begin
			lead.msb[1] = 1'b1;
			v2 = v4[3:2];
		end else begin
			v2 = v4[1:0];
		end
		lead.msb[0] = v2[1];
	end

endmodule

>>> rtl/custom_float_to_double.sv
// an input beat is registered in stage 1, then stage 2, then stage 3
// throughput: one beat per cycle while out_ready is high; each of the three
// stages has its own ready, so bubbles close up and a stalled result holds
// the input only once all three stages are full
// reset: arst_n clears all valid bits and sets the format to 32/8/23
// configuration writes complete in the cycle they are offered
module custom_float_to_double
	import cfd_pkg::*;
#(
	parameter int IN_WIDTH = IN_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [5:0]       cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [PAT_W-1:0] pattern,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [63:0]      double_bits,
	output logic             overflowed
);

	localparam logic [PAT_W-1:0] InMask = PAT_W'((64'd1 << IN_WIDTH) - 64'd1);

	logic [5:0] total_width_q;
	logic [3:0] exp_bits_q;
	logic [4:0] mant_bits_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_width_q <= 6'd32;
			exp_bits_q    <= 4'd8;
			mant_bits_q   <= 5'd23;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TOTAL_WIDTH: total_width_q <= cfg_data;
				CFG_EXP_BITS:    exp_bits_q    <= cfg_data[3:0];
				CFG_MANT_BITS:   mant_bits_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// handshake
	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;

	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// stage 1: field extraction
	logic [PAT_W-1:0]   pat_m, sh_pat, fmask, frac, hidden, sig_c;
	logic [3:0]         e_eff;
	logic [10:0]        emask, expo, eff;
	logic [9:0]         bias;
	logic signed [12:0] k_c;
	logic               sign_c;

	always_comb begin
		pat_m = pattern & InMask;
		if (exp_bits_q == 4'd0) begin
			e_eff = 4'd1;
		end else if (exp_bits_q > 4'(EXP_MAX)) begin
			e_eff = 4'(EXP_MAX);
		end else begin
			e_eff = exp_bits_q;
		end
		emask  = 11'((12'd1 << e_eff) - 12'd1);
		sh_pat = pat_m >> mant_bits_q;
		expo   = sh_pat[10:0] & emask;
		fmask  = PAT_W'((33'd1 << mant_bits_q) - 33'd1);
		frac   = pat_m & fmask;
		hidden = PAT_W'(33'd1 << mant_bits_q);
		sig_c  = (expo == '0) ? frac : (frac | hidden);
		bias   = 10'((11'd1 << (e_eff - 4'd1)) - 11'd1);
		eff    = (expo == '0) ? 11'd1 : expo;
		k_c    = $signed({2'b00, eff}) - $signed({3'b000, bias})
			- $signed({8'd0, mant_bits_q});
		if (total_width_q != 6'd0 && total_width_q <= 6'(PAT_W)) begin
			sign_c = pat_m[5'(total_width_q - 6'd1)];
		end else begin
			sign_c = 1'b0;
		end
	end

	logic [PAT_W-1:0]   sig_s1;
	logic signed [12:0] k_s1;
	logic               sign_s1;

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			sig_s1  <= sig_c;
			k_s1    <= k_c;
			sign_s1 <= sign_c;
		end
	end

	// stage 2: leading one and unbiased exponent
	lead_t lead;

	cfd_lead_one u_lead (
		.sig  (sig_s1),
		.lead (lead)
	);

	logic [PAT_W-1:0]   sig_s2;
	logic signed [12:0] k_s2, u_s2;
	logic [4:0]         p_s2;
	logic               zero_s2, sign_s2;

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			sig_s2  <= sig_s1;
			k_s2    <= k_s1;
			u_s2    <= k_s1 + $signed({8'd0, lead.msb});
			p_s2    <= lead.msb;
			zero_s2 <= lead.zero;
			sign_s2 <= sign_s1;
		end
	end

	// stage 3: pack
	logic [PAT_W-1:0]          norm;
	logic signed [12:0]        sh_full;
	logic [5:0]                sh;
	logic [DBL_FRAC_W-1:0]     sub_frac;
	logic [62:0]               mag;
	logic                      ovf_c;

	always_comb begin
		norm    = sig_s2 << (5'd31 - p_s2);
		sh_full = k_s2 + 13'(DBL_SUB_OFS);
		if (sh_full < 13'sd0) begin
			sh = 6'd0;
		end else if (sh_full > 13'(DBL_FRAC_W)) begin
			sh = 6'(DBL_FRAC_W);
		end else begin
			sh = sh_full[5:0];
		end
		sub_frac = DBL_FRAC_W'({20'd0, sig_s2} << sh);
		ovf_c    = 1'b0;
		priority if (zero_s2) begin
			mag = '0;
		end else if (u_s2 > 13'(DBL_BIAS)) begin
			mag   = {11'h7FF, 52'd0};
			ovf_c = 1'b1;
		end else if (u_s2 >= -13'sd1022) begin
			mag = {11'(u_s2 + 13'(DBL_BIAS)), norm[30:0], 21'd0};
		end else begin
			mag = {11'd0, sub_frac};
		end
	end

	logic [63:0] bits_s3;
	logic        ovf_s3;

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			bits_s3 <= {sign_s2, mag};
			ovf_s3  <= ovf_c;
		end
	end

	assign out_valid   = valid_s3;
	assign double_bits = bits_s3;
	assign overflowed  = ovf_s3;

	a_ovf_inf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflowed |-> double_bits[62:0] == {11'h7FF, 52'd0})
		else $error("overflow beat is not infinity");

	a_inf_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && double_bits[62:52] == 11'h7FF |-> overflowed)
		else $error("all-ones exponent without overflow flag");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(sig_s1))
		else $error("stage 1 lost a stalled beat");

	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !out_ready |=> valid_s3 && $stable(bits_s3))
		else $error("result beat changed while stalled");

endmodule

>>> tb/tb_top.sv
module tb_top;
	import cfd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_TOTAL_WIDTH;
	logic [5:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] pattern = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] double_bits;
	logic        overflowed;

	typedef struct packed {
		logic [63:0] bits;
		logic        ovf;
	} dbl_result_t;

	dbl_result_t expected_doubles[$];
	logic [5:0]  fmt_width = 6'd32;
	logic [3:0]  fmt_exp = 4'd8;
	logic [4:0]  fmt_mant = 5'd23;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          mismatches = 0;
	int          beats_in = 0;
	int          beats_out = 0;
	int          idle_cycles = 0;
	bit          done = 1'b0;

	localparam int WATCHDOG_LIMIT = 20000;

	custom_float_to_double uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .pattern(pattern),
		.out_valid(out_valid), .out_ready(out_ready),
		.double_bits(double_bits), .overflowed(overflowed)
	);

	always #6 clk = ~clk;

	function automatic int top_bit(logic [63:0] v);
		int p;
		p = -1;
		for (int i = 0; i < 64; i++)
			if (v[i]) p = i;
		return p;
	endfunction

	function automatic dbl_result_t decode_minifloat(logic [31:0] pat);
		dbl_result_t r;
		int e, m, p;
		longint bias, k, u, sh;
		logic [63:0] expo, frac, sig, res;
		logic sgn;
		e = fmt_exp;
		m = fmt_mant;
		if (e < 1) e = 1;
		if (e > 11) e = 11;
		sgn = (fmt_width != 0 && fmt_width - 1 < 32) ? pat[fmt_width - 1] : 1'b0;
		expo = ({32'd0, pat} >> m) & ((64'd1 << e) - 1);
		frac = {32'd0, pat} & ((64'd1 << m) - 1);
		bias = (longint'(1) << (e - 1)) - 1;
		if (expo == 0) begin
			sig = frac;
			k = 1 - bias - m;
		end else begin
			sig = (64'd1 << m) | frac;
			k = longint'(expo) - bias - m;
		end
		r.ovf = 1'b0;
		if (sig == 0) begin
			res = '0;
		end else begin
			p = top_bit(sig);
			u = p + k;
			if (u > 1023) begin
				res = 64'h7FF << 52;
				r.ovf = 1'b1;
			end else if (u >= -1022) begin
				res = (64'(u + 1023) << 52) | ((sig << (52 - p)) & ((64'd1 << 52) - 1));
			end else begin
				sh = k + 1074;
				if (sh < 0) sh = 0;
				if (sh > 52) sh = 52;
				res = (sig << sh) & ((64'd1 << 52) - 1);
			end
		end
		r.bits = res | (64'(sgn) << 63);
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		dbl_result_t exp_r;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				beats_out <= beats_out + 1;
				if (expected_doubles.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("unexpected result beat %h", double_bits);
				end else begin
					exp_r = expected_doubles.pop_front();
					if (double_bits !== exp_r.bits || overflowed !== exp_r.ovf) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("mismatch: expected %h/%b got %h/%b", exp_r.bits,
								exp_r.ovf, double_bits, overflowed);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_pattern(logic [31:0] pat);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pattern <= pat;
		do @(posedge clk); while (!in_ready);
		expected_doubles.push_back(decode_minifloat(pat));
		beats_in++;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_doubles.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [5:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TOTAL_WIDTH: fmt_width = val;
			CFG_EXP_BITS:    fmt_exp = val[3:0];
			default:         fmt_mant = val[4:0];
		endcase
	endtask

	task automatic set_format(logic [5:0] w, logic [3:0] e, logic [4:0] m);
		drain();
		write_reg(CFG_TOTAL_WIDTH, w);
		write_reg(CFG_EXP_BITS, {2'b00, e});
		write_reg(CFG_MANT_BITS, {1'b0, m});
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_format;
		send_pattern(32'h0000_0000);
		send_pattern(32'h8000_0000);
		send_pattern(32'h3F80_0000);
		send_pattern(32'hFFFF_FFFF);
		send_pattern(32'h7F7F_FFFF);
		send_pattern(32'h0000_0001);
		send_pattern(32'h807F_FFFF);
		send_pattern(32'hAAAA_AAAA);
		send_pattern(32'h5555_5555);
	endtask

	task automatic test_edge_formats;
		// overflow: wide mantissa, full exponent
		set_format(6'd32, 4'd11, 5'd20);
		send_pattern(32'h7FFF_FFFF);
		send_pattern(32'hFFF0_0000);
		// deep subnormal
		set_format(6'd32, 4'd11, 5'd30);
		send_pattern(32'h0000_0001);
		send_pattern(32'h8000_0000);
		// clamped exponent widths and zero mantissa width
		set_format(6'd3, 4'd0, 5'd0);
		send_pattern(32'h0000_0007);
		send_pattern(32'h0000_0004);
		set_format(6'd0, 4'd15, 5'd31);
		send_pattern(32'hFFFF_FFFF);
		send_pattern(32'h8000_0001);
		set_format(6'd63, 4'd12, 5'd1);
		send_pattern(32'hFFFF_FFFF);
		set_format(6'd33, 4'd1, 5'd30);
		send_pattern(32'hC000_0001);
	endtask

	task automatic random_phase(int n, bit any_fmt);
		for (int i = 0; i < n; i++) begin
			if (i % 60 == 0) begin
				if (any_fmt)
					set_format(6'($urandom), 4'($urandom), 5'($urandom));
				else
					set_format(6'($urandom_range(32, 3)), 4'($urandom_range(11, 1)),
						5'($urandom_range(30, 1)));
			end
			case ($urandom_range(3))
				0: send_pattern($urandom & (32'hFFFF_FFFF >> $urandom_range(31)));
				1: send_pattern({1'($urandom_range(1)), 31'($urandom)});
				default: send_pattern($urandom);
			endcase
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 6;
		recv_idle_pct = 48;
		test_reset_format();
		test_edge_formats();
		random_phase(240, 1'b0);
		// hold off until the pipeline is empty
		drain();
		send_idle_pct = 48;
		recv_idle_pct = 6;
		random_phase(240, 1'b1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(240, 1'b0);
		drain();
		done = 1'b1;
		$display("%0d patterns converted, %0d results checked over random formats",
			beats_in, beats_out);
		if (mismatches == 0 && expected_doubles.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILURE");
		end
		$finish;
	end

endmodule

>>> custom_float_to_double.f
rtl/cfd_pkg.sv
rtl/cfd_lead_one.sv
rtl/custom_float_to_double.sv
tb/tb_top.sv
